>>> rtl/assert_macros.svh
// Assertion macros for the checker of the tile writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/ptpw_pkg.sv
// Shared constants, types and the palette for the planar tile writer.
package ptpw_pkg;

   // Frame geometry
   localparam int FRAME_PIXELS_WIDE = 128;
   localparam int FRAME_PIXELS_HIGH = 112;
   localparam int TILE_LINES        = 8;
   localparam int PIXELS_PER_WRITE  = 8;
   localparam int HEADER_BYTES      = 3;

   localparam int TILE_COLS = FRAME_PIXELS_WIDE / PIXELS_PER_WRITE;
   localparam int COL_W     = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
   localparam int LINE_W    = (TILE_LINES > 1) ? $clog2(TILE_LINES) : 1;
   localparam int ROW_W     = $clog2(FRAME_PIXELS_HIGH + TILE_LINES + 1);
   localparam int HDR_W     = $clog2(HEADER_BYTES + 1);

   // Fixed field widths
   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 14;
   localparam int PIXEL_W  = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_COMMAND = 2'd0,
      ACT_DATA    = 2'd1,
      ACT_COMMIT  = 2'd2
   } action_type;

   typedef logic [PIXEL_W-1:0] pixel_type;
   // Element k is the k-th pixel from the left (plane bit 7-k)
   typedef pixel_type [PIXELS_PER_WRITE-1:0] pixel_row_type;

   localparam pixel_type PALETTE [4] = '{16'h80FF, 16'h8055, 16'h80AA, 16'h8000};

   typedef struct packed {
      logic                write_valid;
      logic [ADDR_W-1:0]   pixel_address;
      pixel_row_type       pixels;
      logic                frame_done;
      logic                busy_led;
   } result_type;

endpackage

>>> rtl/ptpw_channels.sv
// Channel interfaces: input items, results and the configuration write.
interface ptpw_req_if import ptpw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface ptpw_rsp_if import ptpw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [ADDR_W-1:0] pixel_address;
   logic [PIXEL_W-1:0] pixel_0;
   logic [PIXEL_W-1:0] pixel_1;
   logic [PIXEL_W-1:0] pixel_2;
   logic [PIXEL_W-1:0] pixel_3;
   logic [PIXEL_W-1:0] pixel_4;
   logic [PIXEL_W-1:0] pixel_5;
   logic [PIXEL_W-1:0] pixel_6;
   logic [PIXEL_W-1:0] pixel_7;
   logic              frame_done;
   logic              busy_led;

   modport source (output valid, write_valid, pixel_address, pixel_0, pixel_1, pixel_2,
                   pixel_3, pixel_4, pixel_5, pixel_6, pixel_7, frame_done, busy_led,
                   input ready);
   modport sink   (input valid, write_valid, pixel_address, pixel_0, pixel_1, pixel_2,
                   pixel_3, pixel_4, pixel_5, pixel_6, pixel_7, frame_done, busy_led,
                   output ready);
endinterface

interface ptpw_csr_if import ptpw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/ptpw_pixel_decode.sv
// Two-bitplane to palette pixel decode for one eight-pixel line.
module ptpw_pixel_decode import ptpw_pkg::*; (
   input  logic [BYTE_W-1:0] low_plane,
   input  logic [BYTE_W-1:0] high_plane,
   output pixel_row_type     pixels
);

   // Combine plane bits into a color index, leftmost pixel from bit 7
   always_comb begin
      for (int k = 0; k < PIXELS_PER_WRITE; k++) begin
         pixels[k] = PALETTE[{high_plane[BYTE_W-1-k], low_plane[BYTE_W-1-k]}];
      end
   end

endmodule

>>> rtl/planar_tile_to_pixel_writer.sv
// Top level of the planar tile to pixel writer.
//
//  channel | dir | payload                                   | accepted when
//  req     | in  | action, data_byte                         | valid && ready
//  rsp     | out | write_valid, pixel_address, pixel_0..7,   | valid && ready
//          |     | frame_done, busy_led                      |
//  csr     | in  | data (transfer code)                      | valid && ready
//
// One transaction in, one result out; the result is valid in the cycle after the
// transaction is taken, and a new transaction is taken every cycle unless a stall on
// rsp holds it off. The result register is the only stage: req.ready is high while it
// is empty or being drained, so a stall on rsp holds off req. csr.ready is always high.
// Synchronous active-high reset clears the control state and sets the transfer code to 4.
module planar_tile_to_pixel_writer import ptpw_pkg::*; (
   input logic       clock,
   input logic       reset,
   ptpw_req_if.sink  req,
   ptpw_rsp_if.source rsp,
   ptpw_csr_if.sink  csr
);

   localparam logic [BYTE_W-1:0] CODE_RESET = 8'd4;

   logic [BYTE_W-1:0] transfer_code_ff;
   logic              armed_ff, armed_in;
   logic [HDR_W-1:0]  byte_count_ff, byte_count_in;
   logic              pair_phase_ff, pair_phase_in;
   logic [BYTE_W-1:0] low_plane_ff, low_plane_in;
   logic [COL_W-1:0]  tile_column_ff, tile_column_in;
   logic [ROW_W-1:0]  tile_row_base_ff, tile_row_base_in;
   logic [LINE_W-1:0] line_in_tile_ff, line_in_tile_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;

   logic              accept;
   logic              do_write;
   logic              do_done;
   logic [ADDR_W-1:0] addr_full;
   pixel_row_type     pixels;

   // Configuration register
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_code_ff <= CODE_RESET;
      end else if (csr.valid) begin
         transfer_code_ff <= csr.data;
      end
   end

   // Take a transaction whenever the result register is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Next state for one transaction
   always_comb begin
      armed_in         = armed_ff;
      byte_count_in    = byte_count_ff;
      pair_phase_in    = pair_phase_ff;
      low_plane_in     = low_plane_ff;
      tile_column_in   = tile_column_ff;
      tile_row_base_in = tile_row_base_ff;
      line_in_tile_in  = line_in_tile_ff;
      do_write         = 1'b0;
      do_done          = 1'b0;
      unique case (action_type'(req.action))
         ACT_COMMAND: begin
            armed_in         = (req.data_byte == transfer_code_ff);
            byte_count_in    = '0;
            pair_phase_in    = 1'b0;
            tile_column_in   = '0;
            tile_row_base_in = '0;
            line_in_tile_in  = '0;
         end
         ACT_DATA: begin
            if (armed_ff) begin
               if (byte_count_ff < HDR_W'(HEADER_BYTES)) begin
                  byte_count_in = byte_count_ff + 1'b1;
               end else if (!pair_phase_ff) begin
                  low_plane_in  = req.data_byte;
                  pair_phase_in = 1'b1;
               end else begin
                  pair_phase_in = 1'b0;
                  do_write      = 1'b1;
                  // Advance down the tile, then across, then to the next tile row
                  if (line_in_tile_ff == LINE_W'(TILE_LINES - 1)) begin
                     line_in_tile_in = '0;
                     if (tile_column_ff == COL_W'(TILE_COLS - 1)) begin
                        tile_column_in = '0;
                        if (tile_row_base_ff + ROW_W'(TILE_LINES) >=
                            ROW_W'(FRAME_PIXELS_HIGH)) begin
                           tile_row_base_in = '0;
                        end else begin
                           tile_row_base_in = tile_row_base_ff + ROW_W'(TILE_LINES);
                        end
                     end else begin
                        tile_column_in = tile_column_ff + 1'b1;
                     end
                  end else begin
                     line_in_tile_in = line_in_tile_ff + 1'b1;
                  end
               end
            end
         end
         ACT_COMMIT: begin
            do_done  = armed_ff;
            armed_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Frame index of the leftmost pixel
   assign addr_full = ADDR_W'((32'(tile_row_base_ff) + 32'(line_in_tile_ff))
                              * 32'(FRAME_PIXELS_WIDE)
                              + 32'(tile_column_ff) * 32'(PIXELS_PER_WRITE));

   ptpw_pixel_decode u_decode (
      .low_plane  (low_plane_ff),
      .high_plane (req.data_byte),
      .pixels     (pixels)
   );

   // Build the result; zero the write fields when nothing is written
   always_comb begin
      result_in.write_valid   = do_write;
      result_in.pixel_address = do_write ? addr_full : '0;
      result_in.pixels        = do_write ? pixels : '0;
      result_in.frame_done    = do_done;
      result_in.busy_led      = armed_in;
   end

   // Hold the result until it is taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= 1'b0;
         byte_count_ff    <= '0;
         pair_phase_ff    <= 1'b0;
         low_plane_ff     <= '0;
         tile_column_ff   <= '0;
         tile_row_base_ff <= '0;
         line_in_tile_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            armed_ff         <= armed_in;
            byte_count_ff    <= byte_count_in;
            pair_phase_ff    <= pair_phase_in;
            low_plane_ff     <= low_plane_in;
            tile_column_ff   <= tile_column_in;
            tile_row_base_ff <= tile_row_base_in;
            line_in_tile_ff  <= line_in_tile_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   // Drive the result channel
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.write_valid   = result_ff.write_valid;
   assign rsp.pixel_address = result_ff.pixel_address;
   assign rsp.pixel_0       = result_ff.pixels[0];
   assign rsp.pixel_1       = result_ff.pixels[1];
   assign rsp.pixel_2       = result_ff.pixels[2];
   assign rsp.pixel_3       = result_ff.pixels[3];
   assign rsp.pixel_4       = result_ff.pixels[4];
   assign rsp.pixel_5       = result_ff.pixels[5];
   assign rsp.pixel_6       = result_ff.pixels[6];
   assign rsp.pixel_7       = result_ff.pixels[7];
   assign rsp.frame_done    = result_ff.frame_done;
   assign rsp.busy_led      = result_ff.busy_led;

endmodule

>>> rtl/ptpw_checker.sv
// Port-level checker for the planar tile writer, bound to the top level.
`include "assert_macros.svh"

module ptpw_checker import ptpw_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               write_valid,
   input logic [ADDR_W-1:0]  pixel_address,
   input logic [PIXEL_W-1:0] pixel_0,
   input logic               frame_done,
   input logic               busy_led
);

   // An accepted transaction shows a result on the next cycle
   `ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid && req_ready, rsp_valid)

   // A stalled result holds its address
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_address))

   // A write happens only while armed
   `ASSERT_IMPLIES(a_write_armed, clock, reset, rsp_valid && write_valid, busy_led)

   // A finished frame leaves the block disarmed and carries no write
   `ASSERT_IMPLIES(a_done_disarms, clock, reset, rsp_valid && frame_done, !busy_led && !write_valid)

   // No write shows zero address and pixels
   `ASSERT_IMPLIES(a_idle_zero, clock, reset, rsp_valid && !write_valid, pixel_address == '0 && pixel_0 == '0)

endmodule

bind planar_tile_to_pixel_writer ptpw_checker u_ptpw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .write_valid   (rsp.write_valid),
   .pixel_address (rsp.pixel_address),
   .pixel_0       (rsp.pixel_0),
   .frame_done    (rsp.frame_done),
   .busy_led      (rsp.busy_led)
);

>>> bench/tb_planar_tile_to_pixel_writer.sv
// Self-checking testbench for the planar tile to pixel writer.
`timescale 1ns / 1ps

module tb_planar_tile_to_pixel_writer;
   import ptpw_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam pixel_type SHADE [4] = '{16'h80FF, 16'h8055, 16'h80AA, 16'h8000};
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset;

   ptpw_req_if req_ch ();
   ptpw_rsp_if rsp_ch ();
   ptpw_csr_if csr_ch ();

   planar_tile_to_pixel_writer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #10 clock = ~clock;

   // Traffic shaping for the current phase
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Shadow of the decoder state
   logic [BYTE_W-1:0] exp_code;
   logic              exp_armed;
   logic [HDR_W-1:0]  exp_header_seen;
   logic              exp_high_next;
   logic [BYTE_W-1:0] exp_low_plane;
   logic [COL_W-1:0]  exp_tile_col;
   logic [ROW_W-1:0]  exp_row_base;
   logic [LINE_W-1:0] exp_line;

   result_type due_results [$];
   int mismatch_count = 0;
   int taken_items    = 0;

   // Work out the result of one transaction and advance the shadow state
   function automatic result_type decode_item(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b);
      result_type r;
      logic [1:0] shade_idx;
      int addr;
      r = '0;
      case (act)
         ACT_COMMAND: begin
            exp_armed       = (b == exp_code);
            exp_header_seen = '0;
            exp_high_next   = 1'b0;
            exp_tile_col    = '0;
            exp_row_base    = '0;
            exp_line        = '0;
         end
         ACT_DATA: begin
            if (exp_armed) begin
               if (exp_header_seen < HEADER_BYTES) begin
                  exp_header_seen = exp_header_seen + 1'b1;
               end else if (!exp_high_next) begin
                  exp_low_plane = b;
                  exp_high_next = 1'b1;
               end else begin
                  exp_high_next = 1'b0;
                  r.write_valid = 1'b1;
                  addr = (int'(exp_row_base) + int'(exp_line)) * FRAME_PIXELS_WIDE
                       + int'(exp_tile_col) * PIXELS_PER_WRITE;
                  r.pixel_address = addr[ADDR_W-1:0];
                  for (int k = 0; k < PIXELS_PER_WRITE; k++) begin
                     shade_idx = {b[7-k], exp_low_plane[7-k]};
                     r.pixels[k] = SHADE[shade_idx];
                  end
                  // Step down the tile, then across, then to the next tile row
                  if (int'(exp_line) == TILE_LINES - 1) begin
                     exp_line = '0;
                     if (int'(exp_tile_col) == TILE_COLS - 1) begin
                        exp_tile_col = '0;
                        if (int'(exp_row_base) + TILE_LINES >= FRAME_PIXELS_HIGH)
                           exp_row_base = '0;
                        else
                           exp_row_base = exp_row_base + TILE_LINES;
                     end else begin
                        exp_tile_col = exp_tile_col + 1'b1;
                     end
                  end else begin
                     exp_line = exp_line + 1'b1;
                  end
               end
            end
         end
         ACT_COMMIT: begin
            r.frame_done = exp_armed;
            exp_armed    = 1'b0;
         end
         default: ;
      endcase
      r.busy_led = exp_armed;
      return r;
   endfunction

   // Send one transaction, with a random hold-off before it
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      if (act != ACT_UNUSED && !(act == ACT_DATA && !exp_armed))
         taken_items++;
      due_results.push_back(decode_item(act, b));
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_transfer_code(input logic [BYTE_W-1:0] code);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= code;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      exp_code = code;
   endtask

   task automatic note_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t mismatch in %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) note_mismatch(what, want, got);
   endtask

   // Check each result transaction against the oldest pending one
   task automatic check_result();
      result_type due;
      pixel_type  seen [PIXELS_PER_WRITE];
      if (due_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t result transaction with none pending", $realtime);
         return;
      end
      due = due_results.pop_front();
      seen[0] = rsp_ch.pixel_0;
      seen[1] = rsp_ch.pixel_1;
      seen[2] = rsp_ch.pixel_2;
      seen[3] = rsp_ch.pixel_3;
      seen[4] = rsp_ch.pixel_4;
      seen[5] = rsp_ch.pixel_5;
      seen[6] = rsp_ch.pixel_6;
      seen[7] = rsp_ch.pixel_7;
      compare_field("write_valid", 16'(due.write_valid), 16'(rsp_ch.write_valid));
      compare_field("pixel_address", 16'(due.pixel_address), 16'(rsp_ch.pixel_address));
      for (int k = 0; k < PIXELS_PER_WRITE; k++)
         compare_field($sformatf("pixel_%0d", k), due.pixels[k], seen[k]);
      compare_field("frame_done", 16'(due.frame_done), 16'(rsp_ch.frame_done));
      compare_field("busy_led", 16'(due.busy_led), 16'(rsp_ch.busy_led));
   endtask

   // Accept results, with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Data, commit and unused action while nothing is armed
   task automatic test_ignored_items();
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_COMMIT, 8'h00);
      send_item(ACT_UNUSED, 8'hFF);
      wait_idle();
   endtask

   // Header skip, every colour index in every pixel position
   task automatic test_pixel_decode();
      send_item(ACT_COMMAND, 8'h04);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'h5A);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_UNUSED, 8'h00);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hA5);
      send_item(ACT_DATA, 8'h3C);
      wait_idle();
   endtask

   // Commit ends the armed transfer; a foreign command disarms
   task automatic test_commit_and_disarm();
      send_item(ACT_COMMIT, 8'hFF);
      send_item(ACT_COMMIT, 8'h00);
      send_item(ACT_COMMAND, 8'h04);
      send_item(ACT_COMMAND, 8'h05);
      send_item(ACT_DATA, 8'h81);
      send_item(ACT_COMMIT, 8'h00);
      wait_idle();
   endtask

   // Lowest and highest transfer codes
   task automatic test_code_extremes();
      write_transfer_code(8'h00);
      send_item(ACT_COMMAND, 8'h00);
      send_item(ACT_COMMAND, 8'h04);
      wait_idle();
      write_transfer_code(8'hFF);
      send_item(ACT_COMMAND, 8'hFF);
      send_item(ACT_COMMIT, 8'h00);
      wait_idle();
   endtask

   // One stream long enough to cross from the first tile row into the next
   task automatic test_long_stream();
      int pairs;
      pairs = TILE_COLS * TILE_LINES + TILE_COLS;
      send_item(ACT_COMMAND, exp_code);
      repeat (HEADER_BYTES + 2 * pairs) send_item(ACT_DATA, 8'($urandom_range(255)));
      send_item(ACT_COMMIT, 8'($urandom_range(255)));
      wait_idle();
   endtask

   // Mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [BYTE_W-1:0] code, input int quota);
      int sel;
      int pairs;
      write_transfer_code(code);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      taken_items        = 0;
      while (taken_items < quota) begin
         sel = $urandom_range(99);
         if (sel < 75) begin
            pairs = ($urandom_range(9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 30);
            send_item(ACT_COMMAND, exp_code);
            repeat (HEADER_BYTES + 2 * pairs) send_item(ACT_DATA, 8'($urandom_range(255)));
            if ($urandom_range(3) == 0) send_item(ACT_DATA, 8'($urandom_range(255)));
            send_item(ACT_COMMIT, 8'($urandom_range(255)));
            if ($urandom_range(7) == 0) send_item(ACT_COMMIT, 8'($urandom_range(255)));
         end else if (sel < 90) begin
            send_item(ACT_COMMAND, exp_code);
            repeat ($urandom_range(0, 8)) send_item(ACT_DATA, 8'($urandom_range(255)));
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            repeat ($urandom_range(0, 3)) send_item(ACT_DATA, 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
         end
      end
      wait_idle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_COMMAND;
      req_ch.data_byte <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= '0;
      exp_code        = 8'd4;
      exp_armed       = 1'b0;
      exp_header_seen = '0;
      exp_high_next   = 1'b0;
      exp_low_plane   = '0;
      exp_tile_col    = '0;
      exp_row_base    = '0;
      exp_line        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_ignored_items();
      test_pixel_decode();
      test_commit_and_disarm();
      test_code_extremes();
      test_long_stream();
      test_random_traffic(0, 0, 8'($urandom_range(255)), 125);
      test_random_traffic(52, 0, 8'h00, 125);
      test_random_traffic(0, 52, 8'hFF, 125);
      test_random_traffic(11, 11, 8'($urandom_range(255)), 125);

      // Let stragglers arrive, then count anything still pending
      for (int c = 0; c < 2000 && due_results.size() != 0; c++) @(posedge clock);
      repeat (4) @(posedge clock);
      mismatch_count += due_results.size();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #(5_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> planar_tile_to_pixel_writer.f
+incdir+rtl
rtl/ptpw_pkg.sv
rtl/ptpw_channels.sv
rtl/ptpw_pixel_decode.sv
rtl/planar_tile_to_pixel_writer.sv
rtl/ptpw_checker.sv
bench/tb_planar_tile_to_pixel_writer.sv
